/* sv/ljpf_pkg.sv */
package ljpf_pkg;

  localparam int POS_FRAC_BITS_DEF = 24;
  localparam int POS_W  = 32;
  localparam int OUT_W  = 48;
  localparam int COEF_W = 16;
  localparam int Q_W    = 48;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [63:0] FLOOR_Q60 = 64'd115292151;
  localparam logic [63:0] POS_LIM   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM   = 64'h0000_8000_0000_0000;

  localparam logic [POS_W-1:0]  BOX_RST    = 32'd167772160;
  localparam logic [31:0]       CUTOFF_RST = 32'd409600;
  localparam logic [COEF_W-1:0] FCOEF_RST  = 16'd12288;
  localparam logic [COEF_W-1:0] ECOEF_RST  = 16'd1024;

  typedef enum logic [1:0] {
    REG_BOX,
    REG_CUTOFF,
    REG_FCOEF,
    REG_ECOEF
  } reg_idx_t;

  // one wrapped displacement component
  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] mag;
  } disp_t;

  // clamp a magnitude into the signed output range and apply the sign
  function automatic logic [OUT_W-1:0] sat_out(input logic [63:0] mag, input logic ovf,
                                               input logic neg);
    logic [63:0] m;
    if (neg) begin
      m = (ovf || mag > NEG_LIM) ? NEG_LIM : mag;
      return OUT_W'(64'd0 - m);
    end else begin
      m = (ovf || mag > POS_LIM) ? POS_LIM : mag;
      return OUT_W'(m);
    end
  endfunction

endpackage

/* sv/ljpf_dly.sv */
module ljpf_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  // shift one place per advance
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

/* sv/ljpf_mul.sv */
module ljpf_mul #(
  parameter int B_W = 32,
  parameter int SH  = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [63:0]    a,
  input  logic [B_W-1:0] b,
  output logic [63:0]    val,
  output logic           ovf
);

  localparam int NB  = (B_W > 32) ? 2 : 1;
  localparam int BH  = B_W / NB;
  localparam int P_W = 64 + B_W;
  localparam int S_W = (P_W + 1 > SH + 65) ? P_W + 1 : SH + 65;

  logic [32+BH-1:0] pp [2][NB];
  logic [S_W-1:0]   sum;

  // partial products of the 32-bit slices of a and the BH-bit slices of b
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ia = 0; ia < 2; ia++) begin
        for (int ib = 0; ib < NB; ib++) begin
          pp[ia][ib] <= a[32*ia +: 32] * b[BH*ib +: BH];
        end
      end
    end
  end

  // combine with half-up rounding
  always_comb begin
    sum = S_W'(1) << (SH - 1);
    for (int ia = 0; ia < 2; ia++) begin
      for (int ib = 0; ib < NB; ib++) begin
        sum = sum + (S_W'(pp[ia][ib]) << (32*ia + BH*ib));
      end
    end
  end

  // drop fraction bits, flag anything past 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      val <= sum[SH +: 64];
      ovf <= |sum[S_W-1:SH+64];
    end
  end

endmodule

/* sv/ljpf_wrap.sv */
module ljpf_wrap (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ljpf_pkg::POS_W-1:0] a,
  input  logic [ljpf_pkg::POS_W-1:0] b,
  input  logic [ljpf_pkg::POS_W-1:0] box_len,
  output ljpf_pkg::disp_t           disp
);
  import ljpf_pkg::*;

  localparam int STEPS = POS_W;

  logic [POS_W-1:0] m0;
  logic             n0;
  logic [POS_W-1:0] rem [STEPS];
  logic [POS_W-1:0] dvd [STEPS];
  logic             nn  [STEPS];
  logic [POS_W-1:0] r;
  logic             up;

  // raw difference magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      n0 <= a < b;
      m0 <= (a < b) ? b - a : a - b;
    end
  end

  // remainder by the box length, one dividend bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [POS_W-1:0] rem_in;
    logic [POS_W-1:0] dvd_in;
    logic             n_in;
    logic [POS_W:0]   t;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = m0;
      assign n_in   = n0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign dvd_in = dvd[j-1];
      assign n_in   = nn[j-1];
    end
    assign t = {rem_in, dvd_in[POS_W-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, box_len}) begin
          rem[j] <= POS_W'(t - {1'b0, box_len});
        end else begin
          rem[j] <= t[POS_W-1:0];
        end
        dvd[j] <= dvd_in << 1;
        nn[j]  <= n_in;
      end
    end
  end

  assign r  = rem[STEPS-1];
  assign up = {r, 1'b0} >= {1'b0, box_len};

  // nearest image: fold the remainder at or past half a box
  always_ff @(posedge clk) begin
    if (en) begin
      if (box_len == '0 || !up) begin
        disp.mag <= r;
        disp.neg <= nn[STEPS-1] && (r != '0);
      end else begin
        disp.mag <= box_len - r;
        disp.neg <= !nn[STEPS-1];
      end
    end
  end

endmodule

/* sv/ljpf_recip.sv */
module ljpf_recip (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ljpf_pkg::Q_W-1:0] q,
  output logic [63:0]             inv
);
  import ljpf_pkg::*;

  localparam int STEPS = 64;

  logic [Q_W-1:0] rem [STEPS];
  logic [63:0]    quo [STEPS];
  logic [Q_W-1:0] dvs [STEPS];

  // restoring division of all ones by q, one quotient bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [Q_W-1:0] rem_in;
    logic [63:0]    quo_in;
    logic [Q_W-1:0] dvs_in;
    logic [Q_W:0]   t;
    logic [Q_W:0]   diff;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvs_in = q;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign quo_in = quo[j-1];
      assign dvs_in = dvs[j-1];
    end
    assign t    = {rem_in, 1'b1};
    assign diff = t - {1'b0, dvs_in};
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, dvs_in}) begin
          rem[j] <= diff[Q_W-1:0];
          quo[j] <= {quo_in[62:0], 1'b1};
        end else begin
          rem[j] <= t[Q_W-1:0];
          quo[j] <= {quo_in[62:0], 1'b0};
        end
        dvs[j] <= dvs_in;
      end
    end
  end

  assign inv = quo[STEPS-1];

endmodule

/* sv/lennard_jones_pair_force_core.sv */
// Lennard-Jones 12-6 pair force core, one pair per transfer.
// The pipeline runs through the 32-step wrap remainder, the 64-step reciprocal
// divider and twelve multiplier stages.
// Throughput: one pair every cycle; a held output stalls the whole pipeline.
// Reset (synchronous, active high) clears the valid bits and loads the
// register defaults; the datapath holds no reset.
module lennard_jones_pair_force_core #(
  parameter int POS_FRAC_BITS = ljpf_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ljpf_pkg::APB_AW-1:0]  paddr,
  input  logic [ljpf_pkg::APB_DW-1:0]  pwdata,
  output logic [ljpf_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ljpf_pkg::POS_W-1:0]   pos_i_x,
  input  logic [ljpf_pkg::POS_W-1:0]   pos_i_y,
  input  logic [ljpf_pkg::POS_W-1:0]   pos_i_z,
  input  logic [ljpf_pkg::POS_W-1:0]   pos_j_x,
  input  logic [ljpf_pkg::POS_W-1:0]   pos_j_y,
  input  logic [ljpf_pkg::POS_W-1:0]   pos_j_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ljpf_pkg::OUT_W-1:0] force_x,
  output logic signed [ljpf_pkg::OUT_W-1:0] force_y,
  output logic signed [ljpf_pkg::OUT_W-1:0] force_z,
  output logic signed [ljpf_pkg::OUT_W-1:0] pair_energy,
  output logic signed [ljpf_pkg::OUT_W-1:0] pair_virial,
  output logic                         interacts
);
  import ljpf_pkg::*;

  localparam int LAT = 115;
  localparam int CSH = 2 * POS_FRAC_BITS - 16;
  localparam int QSH = 2 * POS_FRAC_BITS - 32;
  localparam int FLK = 60 - 2 * POS_FRAC_BITS;
  localparam int FSH = 8 + POS_FRAC_BITS;
  localparam logic [63:0] FLOOR_Q = (FLOOR_Q60 + (64'd1 << FLK) - 64'd1) >> FLK;
  localparam int DW  = $bits(disp_t);

  // configuration registers
  logic [POS_W-1:0]  box_length;
  logic [31:0]       cutoff_sq;
  logic [COEF_W-1:0] force_coef;
  logic [COEF_W-1:0] energy_coef;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length  <= BOX_RST;
      cutoff_sq   <= CUTOFF_RST;
      force_coef  <= FCOEF_RST;
      energy_coef <= ECOEF_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[APB_AW-1:2]))
        REG_BOX:    box_length  <= pwdata[POS_W-1:0];
        REG_CUTOFF: cutoff_sq   <= pwdata[31:0];
        REG_FCOEF:  force_coef  <= pwdata[COEF_W-1:0];
        REG_ECOEF:  energy_coef <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[APB_AW-1:2]))
      REG_BOX:    prdata = APB_DW'(box_length);
      REG_CUTOFF: prdata = APB_DW'(cutoff_sq);
      REG_FCOEF:  prdata = APB_DW'(force_coef);
      REG_ECOEF:  prdata = APB_DW'(energy_coef);
      default:    prdata = '0;
    endcase
  end

  // pipeline advance and valid bits
  logic           adv;
  logic [LAT:1]   vld;

  assign adv       = !(vld[LAT] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // minimum-image displacement per axis
  logic [POS_W-1:0] pa [3];
  logic [POS_W-1:0] pb [3];
  disp_t [2:0]      disp;

  assign pa[0] = pos_i_x;
  assign pa[1] = pos_i_y;
  assign pa[2] = pos_i_z;
  assign pb[0] = pos_j_x;
  assign pb[1] = pos_j_y;
  assign pb[2] = pos_j_z;

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    ljpf_wrap u_wrap (
      .clk     (clk),
      .en      (adv),
      .a       (pa[ax]),
      .b       (pb[ax]),
      .box_len (box_length),
      .disp    (disp[ax])
    );
  end

  // squares, saturating sum, range tests
  logic [63:0]    sq [3];
  logic [65:0]    sum3;
  logic [63:0]    r2;
  logic [63:0]    qf;
  logic [Q_W-1:0] q;
  logic           si;
  logic           inter;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ax = 0; ax < 3; ax++) begin
        sq[ax] <= disp[ax].mag * disp[ax].mag;
      end
    end
  end

  assign sum3 = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
  assign qf   = r2 >> QSH;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2    <= (sum3[65:64] != 2'b00) ? '1 : sum3[63:0];
      inter <= ((r2 >> CSH) < 64'(cutoff_sq)) && (r2 >= FLOOR_Q);
      q     <= qf[Q_W-1:0];
      si    <= qf[Q_W-1:0] <= Q_W'(1);
    end
  end

  // reciprocal of r squared
  logic [63:0] inv;

  ljpf_recip u_recip (
    .clk (clk),
    .en  (adv),
    .q   (q),
    .inv (inv)
  );

  logic si_d103;
  logic inter_d114;

  ljpf_dly #(.W(1), .N(66)) u_dly_si    (.clk(clk), .en(adv), .d(si),    .q(si_d103));
  ljpf_dly #(.W(1), .N(77)) u_dly_inter (.clk(clk), .en(adv), .d(inter), .q(inter_d114));

  // inverse powers
  logic [63:0] p2, p6, p8, p12, p14;
  logic        ovf2, ovf6, ovf8, ovf12, ovf14;
  logic        ss, s6, s8, s12, s14;
  logic        ss_d105, s6_d107, s12_d109, s8_d109;
  logic [63:0] inv_d103, inv_d105, p2_d107, p6_d109, p8_d109, p12_d109;

  ljpf_dly #(.W(64), .N(2)) u_dly_inv1 (.clk(clk), .en(adv), .d(inv),      .q(inv_d103));
  ljpf_dly #(.W(64), .N(2)) u_dly_inv2 (.clk(clk), .en(adv), .d(inv_d103), .q(inv_d105));

  ljpf_mul #(.B_W(64), .SH(32)) u_mul_p2 (
    .clk(clk), .en(adv), .a(inv), .b(inv), .val(p2), .ovf(ovf2)
  );
  assign ss = si_d103 | ovf2;

  ljpf_mul #(.B_W(64), .SH(32)) u_mul_p6 (
    .clk(clk), .en(adv), .a(p2), .b(inv_d103), .val(p6), .ovf(ovf6)
  );
  ljpf_dly #(.W(1), .N(2)) u_dly_ss (.clk(clk), .en(adv), .d(ss), .q(ss_d105));
  assign s6 = ss_d105 | ovf6;

  ljpf_mul #(.B_W(64), .SH(32)) u_mul_p8 (
    .clk(clk), .en(adv), .a(p6), .b(inv_d105), .val(p8), .ovf(ovf8)
  );
  ljpf_mul #(.B_W(64), .SH(32)) u_mul_p12 (
    .clk(clk), .en(adv), .a(p6), .b(p6), .val(p12), .ovf(ovf12)
  );
  ljpf_dly #(.W(1), .N(2)) u_dly_s6 (.clk(clk), .en(adv), .d(s6), .q(s6_d107));
  assign s8  = s6_d107 | ovf8;
  assign s12 = s6_d107 | ovf12;

  ljpf_dly #(.W(64), .N(4)) u_dly_p2 (.clk(clk), .en(adv), .d(p2), .q(p2_d107));
  ljpf_mul #(.B_W(64), .SH(32)) u_mul_p14 (
    .clk(clk), .en(adv), .a(p12), .b(p2_d107), .val(p14), .ovf(ovf14)
  );
  ljpf_dly #(.W(1), .N(2)) u_dly_s12 (.clk(clk), .en(adv), .d(s12), .q(s12_d109));
  assign s14 = s12_d109 | ovf14;

  ljpf_dly #(.W(64), .N(4)) u_dly_p6  (.clk(clk), .en(adv), .d(p6),  .q(p6_d109));
  ljpf_dly #(.W(64), .N(2)) u_dly_p8  (.clk(clk), .en(adv), .d(p8),  .q(p8_d109));
  ljpf_dly #(.W(64), .N(2)) u_dly_p12 (.clk(clk), .en(adv), .d(p12), .q(p12_d109));
  ljpf_dly #(.W(1),  .N(2)) u_dly_s8  (.clk(clk), .en(adv), .d(s8),  .q(s8_d109));

  // force, energy and virial terms as sign and magnitude
  logic [63:0] h8, h6;
  logic [63:0] gm, em, vm;
  logic        gneg, eneg, vneg, gsat, esat;

  assign h8 = p8_d109 >> 1;
  assign h6 = p6_d109 >> 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      gsat <= s14 | s8_d109;
      esat <= s12_d109;
      gneg <= !(s14 | s8_d109) && (p14 < h8);
      gm   <= (p14 < h8) ? h8 - p14 : p14 - h8;
      eneg <= p12_d109 < p6_d109;
      em   <= (p12_d109 < p6_d109) ? p6_d109 - p12_d109 : p12_d109 - p6_d109;
      vneg <= p12_d109 < h6;
      vm   <= (p12_d109 < h6) ? h6 - p12_d109 : p12_d109 - h6;
    end
  end

  // radial force factor
  logic [63:0] fac;
  logic        fac_ovf;
  logic [1:0]  gfl_d112;
  logic [1:0]  ffl_d114;
  logic        fsat;

  ljpf_mul #(.B_W(COEF_W), .SH(8)) u_mul_fac (
    .clk(clk), .en(adv), .a(gm), .b(force_coef), .val(fac), .ovf(fac_ovf)
  );
  ljpf_dly #(.W(2), .N(2)) u_dly_gfl (.clk(clk), .en(adv), .d({gsat, gneg}), .q(gfl_d112));
  assign fsat = gfl_d112[1] | fac_ovf;
  ljpf_dly #(.W(2), .N(2)) u_dly_ffl (
    .clk(clk), .en(adv), .d({fsat, gfl_d112[0]}), .q(ffl_d114)
  );

  // force components
  disp_t [2:0] disp_d112;
  logic [5:0]  dz;
  logic [5:0]  dz_d114;
  logic [63:0] fv [3];
  logic        fv_ovf [3];

  ljpf_dly #(.W(3*DW), .N(78)) u_dly_disp (.clk(clk), .en(adv), .d(disp), .q(disp_d112));

  for (genvar ax = 0; ax < 3; ax++) begin : g_force
    ljpf_mul #(.B_W(POS_W), .SH(FSH)) u_mul_f (
      .clk(clk), .en(adv), .a(fac), .b(disp_d112[ax].mag), .val(fv[ax]), .ovf(fv_ovf[ax])
    );
    assign dz[2*ax]   = disp_d112[ax].mag == '0;
    assign dz[2*ax+1] = disp_d112[ax].neg;
  end

  ljpf_dly #(.W(6), .N(2)) u_dly_dz (.clk(clk), .en(adv), .d(dz), .q(dz_d114));

  // energy and virial scaling
  logic [63:0] ev, vv, ev_d114, vv_d114;
  logic        ev_ovf, vv_ovf, ev_ovf_d114, vv_ovf_d114;
  logic [2:0]  efl_d114;

  ljpf_mul #(.B_W(COEF_W), .SH(16)) u_mul_e (
    .clk(clk), .en(adv), .a(em), .b(energy_coef), .val(ev), .ovf(ev_ovf)
  );
  ljpf_mul #(.B_W(COEF_W), .SH(16)) u_mul_v (
    .clk(clk), .en(adv), .a(vm), .b(force_coef), .val(vv), .ovf(vv_ovf)
  );
  ljpf_dly #(.W(65), .N(2)) u_dly_ev (
    .clk(clk), .en(adv), .d({ev_ovf, ev}), .q({ev_ovf_d114, ev_d114})
  );
  ljpf_dly #(.W(65), .N(2)) u_dly_vv (
    .clk(clk), .en(adv), .d({vv_ovf, vv}), .q({vv_ovf_d114, vv_d114})
  );
  ljpf_dly #(.W(3), .N(4)) u_dly_efl (
    .clk(clk), .en(adv), .d({esat, eneg, vneg}), .q(efl_d114)
  );

  // output register: select, sign and clamp
  logic [OUT_W-1:0] fo [3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      if (!inter_d114 || force_coef == '0 || dz_d114[2*ax]) begin
        fo[ax] = '0;
      end else if (ffl_d114[1]) begin
        fo[ax] = sat_out(64'd0, 1'b1, ffl_d114[0] ^ dz_d114[2*ax+1]);
      end else begin
        fo[ax] = sat_out(fv[ax], fv_ovf[ax], ffl_d114[0] ^ dz_d114[2*ax+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      force_x   <= fo[0];
      force_y   <= fo[1];
      force_z   <= fo[2];
      interacts <= inter_d114;
      if (!inter_d114 || energy_coef == '0) begin
        pair_energy <= '0;
      end else if (efl_d114[2]) begin
        pair_energy <= OUT_W'(POS_LIM);
      end else begin
        pair_energy <= sat_out(ev_d114, ev_ovf_d114, efl_d114[1]);
      end
      if (!inter_d114 || force_coef == '0) begin
        pair_virial <= '0;
      end else if (efl_d114[2]) begin
        pair_virial <= OUT_W'(POS_LIM);
      end else begin
        pair_virial <= sat_out(vv_d114, vv_ovf_d114, efl_d114[0]);
      end
    end
  end

endmodule
